### sv/sha256_byte_stream_hasher_core_macros.svh
// Assertion macros for the SHA-256 core
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH

`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sha_pkg.sv
package sha_pkg;

  typedef struct packed {
    logic init_chain;
    logic load_byte;
    logic [7:0] byte_val;
    logic [5:0] byte_pos;
    logic start_comp;
    logic round_step;
    logic [5:0] round_idx;
    logic finish_comp;
  } sha_cmd_t;

  localparam logic [31:0] SHA_H [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

endpackage

### sv/sha_datapath.sv
module sha_datapath import sha_pkg::*; (
  input  logic clk,
  input  sha_cmd_t cmd,
  input  logic [2:0] rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt, t1, t2, e, a, s0, s1, x, y;
  logic [1:0] bsel;
  logic [3:0] widx;

  assign x = w_r[1];
  assign y = w_r[14];
  assign s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  assign s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
  assign w_nxt = w_r[0] + s0 + w_r[9] + s1;
  assign e = v_r[4];
  assign a = v_r[0];
  assign t1 = v_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & v_r[5]) ^ (~e & v_r[6])) + SHA_K[cmd.round_idx] + w_r[0];
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign bsel = cmd.byte_pos[1:0];
  assign widx = cmd.byte_pos[5:2];
  assign rd_word = h_r[rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.init_chain) begin
      for (int i = 0; i < 8; i++) h_r[i] <= SHA_H[i];
    end else if (cmd.finish_comp) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= e;
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= a;
      v_r[0] <= t1 + t2;
    end
    if (cmd.load_byte) begin
      case (bsel)
        2'd0: w_r[widx] <= {cmd.byte_val, 24'd0};
        2'd1: w_r[widx][23:16] <= cmd.byte_val;
        2'd2: w_r[widx][15:8] <= cmd.byte_val;
        2'd3: w_r[widx][7:0] <= cmd.byte_val;
        default: ;
      endcase
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_nxt;
    end
  end

endmodule

### sv/sha_ctrl.sv
module sha_ctrl import sha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_data_byte,
  input  logic in_has_byte,
  input  logic in_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] out_word_index,
  output logic out_final_word,
  output sha_cmd_t cmd,
  output logic busy
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ROUND, S_FIN, S_PAD, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt, rnd_r, rnd_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] len_r, len_nxt;
  logic closing_r, closing_nxt;
  logic padding_r, padding_nxt;
  logic len_ok_r, len_ok_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic [7:0] pad_byte;
  logic [2:0] len_sel;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = oidx_r;
  assign out_final_word = (oidx_r == 3'd7);
  assign busy = (state_r != S_IDLE);
  assign len_sel = 3'd7 - fill_r[2:0];
  // length bytes only once the marker and any zero block are behind us
  assign pad_byte = (len_ok_r && fill_r >= LEN_POS) ? len_r[{len_sel, 3'b000} +: 8] : 8'd0;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    rnd_nxt = rnd_r;
    bits_nxt = bits_r;
    len_nxt = len_r;
    closing_nxt = closing_r;
    padding_nxt = padding_r;
    len_ok_nxt = len_ok_r;
    oidx_nxt = oidx_r;
    cmd = '0;
    cmd.round_idx = rnd_r;
    cmd.byte_pos = fill_r;
    case (state_r)
      S_INIT: begin
        cmd.init_chain = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.load_byte = 1'b1;
            cmd.byte_val = in_data_byte;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_last) begin
            len_nxt = in_has_byte ? bits_r + 64'd8 : bits_r;
            closing_nxt = 1'b1;
            padding_nxt = 1'b1;
            bits_nxt = '0;
          end
          if (in_has_byte && fill_r == 6'd63) begin
            cmd.start_comp = 1'b1;
            rnd_nxt = '0;
            state_nxt = S_ROUND;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.load_byte = 1'b1;
        cmd.byte_val = closing_r ? PAD_MARK : pad_byte;
        if (closing_r) len_ok_nxt = (fill_r < LEN_POS);
        closing_nxt = 1'b0;
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cmd.start_comp = 1'b1;
          rnd_nxt = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_comp = 1'b1;
        oidx_nxt = '0;
        if (closing_r) begin
          state_nxt = S_PAD;
        end else if (!padding_r) begin
          state_nxt = S_IDLE;
        end else if (len_ok_r) begin
          padding_nxt = 1'b0;
          len_ok_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          len_ok_nxt = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) state_nxt = S_INIT;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      fill_r <= '0;
      rnd_r <= '0;
      bits_r <= '0;
      len_r <= '0;
      closing_r <= 1'b0;
      padding_r <= 1'b0;
      len_ok_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      rnd_r <= rnd_nxt;
      bits_r <= bits_nxt;
      len_r <= len_nxt;
      closing_r <= closing_nxt;
      padding_r <= padding_nxt;
      len_ok_r <= len_ok_nxt;
      oidx_r <= oidx_nxt;
    end
  end

endmodule

### sv/sha256_byte_stream_hasher_core.sv
// SHA-256 over a byte stream. One item is taken per cycle while a block fills;
// the 64th byte of a block starts 64 rounds of the shared round unit and then
// a chaining step, during which no item is taken. A last item pads the block
// one byte per cycle (one or two more compressions), then offers the eight
// digest words, word 0 first, and reloads the initial hash values before the
// next item.
`include "sha256_byte_stream_hasher_core_macros.svh"
module sha256_byte_stream_hasher_core import sha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_data_byte,
  input  logic in_has_byte,
  input  logic in_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0] out_word_index,
  output logic out_final_word
);

  sha_cmd_t cmd;
  logic busy;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_word_index(out_word_index), .out_final_word(out_final_word),
    .cmd(cmd), .busy(busy)
  );

  sha_datapath u_dp (
    .clk(clk), .cmd(cmd), .rd_idx(out_word_index), .rd_word(out_digest_word)
  );

  `SHA_ASSERT_IMPL(a_no_overlap, clk, rst_n, in_ready, !out_valid, "input and output overlap")
  `SHA_ASSERT_IMPL(a_busy, clk, rst_n, busy, !in_ready, "ready while busy")
  `SHA_ASSERT_NEXT(a_final, clk, rst_n, out_valid && out_ready && out_final_word, !out_valid, "extra word")

endmodule
